// ===== rtl/tcs_pkg.sv =====
`default_nettype none
package tcs_pkg;

    // Screen and texture geometry.
    localparam int SCREEN_HEIGHT     = 64;
    localparam int TEXELS_PER_COLUMN = 16;
    localparam int COLUMN_BYTES      = 4;

    // Texture store.
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = ADDR_W + 2;

    // Row arithmetic is signed and wide enough for any wall height.
    localparam int ROW_W = 16;
    typedef logic signed [ROW_W-1:0] t_row;

    localparam t_row CENTER_ROW = t_row'(SCREEN_HEIGHT / 2);
    localparam t_row LAST_ROW   = t_row'(SCREEN_HEIGHT - 1);
    localparam t_row ROW_STEP   = t_row'(15);

    // Texel codes.
    localparam logic [1:0] TEXEL_CHECKER = 2'd0;
    localparam logic [1:0] TEXEL_LIT     = 2'd1;
    localparam logic [1:0] TEXEL_DARK    = 2'd2;
    localparam logic [1:0] TEXEL_INVERSE = 2'd3;

    // Operation codes of the func field.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_DRAW  = 1'b1;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== rtl/tcs_if.sv =====
`default_nettype none
interface tcs_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [6:0]  column_x;
    logic [14:0] wall_height;
    logic [3:0]  texel_column;
    logic [3:0]  texture_id;
    logic [9:0]  write_address;
    logic [7:0]  write_data;

    modport source (
        output valid, func, column_x, wall_height, texel_column, texture_id,
               write_address, write_data,
        input  ready
    );
    modport sink (
        input  valid, func, column_x, wall_height, texel_column, texture_id,
               write_address, write_data,
        output ready
    );
endinterface

interface tcs_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic       pixel_value;
    logic       last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_value, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_value, last,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/tcs_texture_mem.sv =====
`default_nettype none
module tcs_texture_mem (
    input  wire logic             i_clk,
    input  wire tcs_pkg::t_mem_req i_req,
    output logic [7:0]            o_rdata
);
    import tcs_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rdata;

    // Read data is held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/tcs_walker.sv =====
`default_nettype none
module tcs_walker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tcs_in_if.sink                  i_in,
    tcs_out_if.source               o_out,
    output tcs_pkg::t_mem_req       o_mem_req,
    input  wire logic [7:0]         i_mem_rdata
);
    import tcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROW   = 4'b0010,
        S_ADV   = 4'b0100,
        S_FETCH = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [6:0]        r_x, n_x;
    logic [14:0]       r_w, n_w;
    t_row              r_y, n_y;
    t_row              r_y2, n_y2;
    t_row              r_verr, n_verr;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0] r_base, n_base;

    logic              r_out_valid, n_out_valid;
    logic [6:0]        r_out_x, n_out_x;
    logic [5:0]        r_out_y, n_out_y;
    logic              r_out_value, n_out_value;
    logic              r_out_last, n_out_last;

    t_row              half;
    t_row              step_verr;
    t_row              adv_verr;
    logic [1:0]        texel;
    logic              shade;
    logic              row_last;
    logic              out_free;

    assign half      = t_row'(i_in.wall_height[14:1]);
    assign step_verr = r_verr - ROW_STEP;
    assign adv_verr  = r_verr + t_row'(r_w);
    assign texel     = i_mem_rdata[{r_idx[1:0], 1'b0} +: 2];
    assign row_last  = (r_y == r_y2) || (r_y == LAST_ROW);
    assign out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        unique case (texel)
            TEXEL_LIT:     shade = 1'b1;
            TEXEL_DARK:    shade = 1'b0;
            TEXEL_CHECKER: shade = r_x[0] ^ r_y[0];
            TEXEL_INVERSE: shade = !(r_x[0] & r_y[0]);
            default:       shade = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_w         = r_w;
        n_y         = r_y;
        n_y2        = r_y2;
        n_verr      = r_verr;
        n_idx       = r_idx;
        n_base      = r_base;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;

        o_mem_req.we    = 1'b0;
        o_mem_req.re    = 1'b0;
        o_mem_req.addr  = r_base + r_idx[IDX_W-1:2];
        o_mem_req.wdata = i_in.write_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.func == FUNC_WRITE) begin
                        o_mem_req.we   = 1'b1;
                        o_mem_req.addr = i_in.write_address;
                    end else begin
                        n_x     = i_in.column_x;
                        n_w     = i_in.wall_height;
                        n_y     = CENTER_ROW - half;
                        n_y2    = CENTER_ROW + half;
                        n_verr  = half;
                        n_idx   = '0;
                        n_base  = ADDR_W'(int'(i_in.texel_column) * COLUMN_BYTES
                                  + int'(i_in.texture_id) * COLUMN_BYTES
                                  * TEXELS_PER_COLUMN);
                        n_state = S_ROW;
                    end
                end
            end
            S_ROW: begin
                if (r_y >= 0) begin
                    o_mem_req.re = 1'b1;
                    n_state      = S_FETCH;
                end else begin
                    // Rows above the screen only move the walk along.
                    n_y     = r_y + t_row'(1);
                    n_verr  = step_verr;
                    n_state = (step_verr < 0) ? S_ADV : S_ROW;
                end
            end
            S_ADV: begin
                n_idx   = r_idx + IDX_W'(1);
                n_verr  = adv_verr;
                n_state = (adv_verr < 0) ? S_ADV : S_ROW;
            end
            S_FETCH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_x;
                    n_out_y     = r_y[5:0];
                    n_out_value = shade;
                    n_out_last  = row_last;
                    if (row_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_y     = r_y + t_row'(1);
                        n_verr  = step_verr;
                        n_state = (step_verr < 0) ? S_ADV : S_ROW;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_w         <= n_w;
        r_y         <= n_y;
        r_y2        <= n_y2;
        r_verr      <= n_verr;
        r_idx       <= n_idx;
        r_base      <= n_base;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_x     = r_out_x;
    assign o_out.pixel_y     = r_out_y;
    assign o_out.pixel_value = r_out_value;
    assign o_out.last        = r_out_last;

`ifndef NO_ASSERTIONS
    a_fetch_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> $past(r_state) == S_ROW || $past(r_state) == S_FETCH)
        else $error("texel fetch without a preceding memory read");

    a_read_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.re |-> r_state == S_ROW && r_y >= 0)
        else $error("memory read outside a visible row");

    a_adv_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADV |-> r_verr < 0)
        else $error("texel advance with non-negative error");

    a_row_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROW |-> r_y <= r_y2 && r_y <= LAST_ROW)
        else $error("row walk ran past the end of the column");
`endif

endmodule
`default_nettype wire

// ===== rtl/textured_column_scaler.sv =====
`default_nettype none
// Channel   Dir  Word
// i_in      in   func, column_x, wall_height, texel_column, texture_id,
//                write_address, write_data
// o_out     out  pixel_x, pixel_y, pixel_value, last
//
// A write word gives no pixel. A draw word is loaded in the idle state, then
// takes the row state for each row above the screen, the row and fetch states
// for each visible row (texture memory read, then pixel), and the advance state
// for every texel advance of the error walk; the single-port texture memory sets
// this. A stalled output holds the walk in the fetch state. Reset is synchronous
// and clears control only; the texture memory keeps its contents.
module textured_column_scaler (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcs_in_if.sink    i_in,
    tcs_out_if.source o_out
);
    import tcs_pkg::*;

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;

    tcs_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    tcs_texture_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire
